### design/c8_pkg.sv
// Shared types, codes, font table and small helpers for the CHIP-8 core.
// Used by c8_front, c8_back and chip8_instruction_core; depends on nothing.
`timescale 1ns / 1ps
package c8_pkg;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_EXEC  = 2'd1;
  localparam logic [1:0] FUNC_DREAD = 2'd2;
  localparam logic [1:0] FUNC_MREAD = 2'd3;

  localparam logic [11:0] START_PC  = 12'h200;
  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam int          FONT_LEN  = 80;
  localparam int          SCREEN_ROWS = 32;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [15:0] OP_SKP_MASK = 16'hF0FF;
  localparam logic [15:0] OP_SKP = 16'hE09E;
  localparam logic [15:0] OP_SKNP = 16'hE0A1;
  localparam logic [7:0]  F_LDDT = 8'h07;
  localparam logic [7:0]  F_KEY  = 8'h0A;
  localparam logic [7:0]  F_SETDT = 8'h15;
  localparam logic [7:0]  F_SETST = 8'h18;
  localparam logic [7:0]  F_ADDI = 8'h1E;
  localparam logic [7:0]  F_FONT = 8'h29;
  localparam logic [7:0]  F_BCD  = 8'h33;
  localparam logic [7:0]  F_STORE = 8'h55;
  localparam logic [7:0]  F_LOADR = 8'h65;

  localparam logic [7:0] FONT [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] address;
    logic [7:0]  load_byte;
    logic [15:0] keys_down;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] opcode;
    logic [11:0] program_counter_out;
    logic [7:0]  read_byte;
    logic [63:0] display_row;
    logic [4:0]  row_number;
    logic [7:0]  sprite_bits;
    logic        collision;
    logic        screen_cleared;
    logic        key_wait;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    K_LOAD, K_EXEC, K_DREAD, K_MREAD
  } kind_t;

  typedef struct packed {
    kind_t    kind;
    in_item_t item;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MREAD, S_FETCH, S_FETCH2, S_OPC, S_VY, S_EXEC,
    S_DRAW_RD, S_DRAW_WR, S_BCD, S_STORE, S_LD_RD, S_LD_WR
  } state_t;

  // Index of the lowest held key.
  function automatic logic [3:0] lowest_key(logic [15:0] keys);
    logic [3:0] k;
    k = 4'd0;
    for (int j = 15; j >= 0; j--) begin
      if (keys[j]) k = 4'(j);
    end
    return k;
  endfunction

  // Decimal digit of v: 0 hundreds, 1 tens, 2 ones.
  function automatic logic [7:0] bcd_digit(logic [7:0] v, logic [1:0] sel);
    logic [7:0] h;
    logic [7:0] r;
    logic [7:0] t;
    h = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
    r = (v >= 8'd200) ? v - 8'd200 : ((v >= 8'd100) ? v - 8'd100 : v);
    t = 8'd0;
    for (int j = 1; j <= 9; j++) begin
      if (r >= 8'(10 * j)) t = 8'(j);
    end
    case (sel)
      2'd0:    return h;
      2'd1:    return t;
      default: return r - 8'(t * 8'd10);
    endcase
  endfunction

endpackage

### design/c8_front.sv
// Front end of the CHIP-8 core: takes commands, classifies them and queues them.
// Depends on c8_pkg.
`timescale 1ns / 1ps
module c8_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  c8_pkg::in_item_t in_item,
  input  logic             hold,
  input  logic             pop,
  output logic             busy,
  output logic             q_valid,
  output c8_pkg::cmd_t     q_cmd
);
  import c8_pkg::*;

  cmd_t       q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       push;
  kind_t      kind;

  always_comb begin
    case (in_item.func)
      FUNC_LOAD:  kind = K_LOAD;
      FUNC_EXEC:  kind = K_EXEC;
      FUNC_DREAD: kind = K_DREAD;
      default:    kind = K_MREAD;
    endcase
  end

  assign busy    = (cnt_r == 2'd2) || hold;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= '{kind: kind, item: in_item};
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### design/c8_back.sv
// Back end of the CHIP-8 core: memory, register file, screen and the sequencer
// that carries out queued commands. Depends on c8_pkg.
`timescale 1ns / 1ps
module c8_back #(
  parameter int MEMORY_BYTES = 4096,
  parameter int STACK_DEPTH  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  c8_pkg::cmd_t      q_cmd,
  output logic              pop,
  output logic              clearing,
  output logic              out_strobe,
  output c8_pkg::out_item_t out_item
);
  import c8_pkg::*;

  localparam int AW  = $clog2(MEMORY_BYTES);
  localparam int SPW = $clog2(STACK_DEPTH);

  function automatic logic [AW-1:0] maddr(logic [11:0] a);
    logic [13:0] t;
    t = {2'b00, a};
    if (t >= 14'(3 * MEMORY_BYTES))      t = t - 14'(3 * MEMORY_BYTES);
    else if (t >= 14'(2 * MEMORY_BYTES)) t = t - 14'(2 * MEMORY_BYTES);
    else if (t >= 14'(MEMORY_BYTES))     t = t - 14'(MEMORY_BYTES);
    return t[AW-1:0];
  endfunction

  logic [7:0]  mem [MEMORY_BYTES];
  logic [7:0]  mem_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata;

  state_t      state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [11:0] pc_r, pc_nxt, i_r, i_nxt;
  logic [7:0]  v_r [16];
  logic [11:0] stack_r [STACK_DEPTH];
  logic [SPW-1:0] sp_r, sp_nxt, sp_inc, sp_dec;
  logic [7:0]  dt_r, dt_nxt, st_r, st_nxt;
  logic [63:0] screen_r [SCREEN_ROWS];
  logic [15:0] op_r, op_nxt;
  logic [7:0]  hi_r, hi_nxt, vx_r, vx_nxt, vy_r, vy_nxt;
  cmd_t        item_r, item_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        col_r, col_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_strobe_r, out_strobe_nxt;

  logic [3:0]  v_raddr, v_waddr;
  logic [7:0]  v_rdata, v_wdata, vf_wdata;
  logic        v_we, vf_we, stk_we, scr_we, scr_clear;
  logic [4:0]  scr_raddr, scr_waddr;
  logic [63:0] scr_rdata, scr_wdata;

  assign v_rdata   = v_r[v_raddr];
  assign scr_rdata = screen_r[scr_raddr];
  assign sp_inc = (sp_r == SPW'(STACK_DEPTH - 1)) ? '0 : sp_r + 1'b1;
  assign sp_dec = (sp_r == '0) ? SPW'(STACK_DEPTH - 1) : sp_r - 1'b1;
  assign clearing   = (state_r == S_CLEAR);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  always_comb begin
    logic [11:0] pc2;
    logic [3:0]  fn, n, x;
    logic [7:0]  nn;
    logic [8:0]  sum;
    logic        skip, emit;
    logic [127:0] dbl;
    logic [63:0] mask, nrow;
    logic        coln, klast;
    logic [AW-1:0] fidx;

    state_nxt = state_r; clr_cnt_nxt = clr_cnt_r;
    pc_nxt = pc_r; i_nxt = i_r; sp_nxt = sp_r; dt_nxt = dt_r; st_nxt = st_r;
    op_nxt = op_r; hi_nxt = hi_r; vx_nxt = vx_r; vy_nxt = vy_r;
    item_nxt = item_r; k_nxt = k_r; col_nxt = col_r;
    out_nxt = '0; out_strobe_nxt = 1'b0; pop = 1'b0;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = 8'd0; mem_raddr = maddr(pc_r);
    v_raddr = op_r[11:8]; v_we = 1'b0; v_waddr = op_r[11:8]; v_wdata = 8'd0;
    vf_we = 1'b0; vf_wdata = 8'd0; stk_we = 1'b0;
    scr_raddr = vy_r[4:0]; scr_we = 1'b0; scr_waddr = '0; scr_wdata = '0;
    scr_clear = 1'b0;
    pc2 = pc_r + 12'd2; fn = op_r[15:12]; n = op_r[3:0]; x = op_r[11:8];
    nn = op_r[7:0]; sum = '0; skip = 1'b0; emit = 1'b0;
    dbl = '0; mask = '0; nrow = '0; coln = 1'b0; klast = 1'b0;
    fidx = clr_cnt_r - AW'(FONT_BASE);

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_cnt_r;
        if (clr_cnt_r >= AW'(FONT_BASE) && clr_cnt_r < AW'(FONT_BASE) + AW'(FONT_LEN))
          mem_wdata = FONT[fidx[6:0]];
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MEMORY_BYTES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          item_nxt = q_cmd;
          case (q_cmd.kind)
            K_LOAD: begin
              mem_we = 1'b1;
              mem_waddr = maddr(q_cmd.item.address);
              mem_wdata = q_cmd.item.load_byte;
              out_nxt.program_counter_out = pc_r;
              out_nxt.last = 1'b1;
              out_strobe_nxt = 1'b1;
            end
            K_DREAD: begin
              scr_raddr = q_cmd.item.address[4:0];
              out_nxt.program_counter_out = pc_r;
              out_nxt.display_row = scr_rdata;
              out_nxt.row_number = q_cmd.item.address[4:0];
              out_nxt.last = 1'b1;
              out_strobe_nxt = 1'b1;
            end
            K_MREAD: begin
              mem_raddr = maddr(q_cmd.item.address);
              state_nxt = S_MREAD;
            end
            default: begin
              mem_raddr = maddr(pc_r);
              state_nxt = S_FETCH;
            end
          endcase
        end
      end
      S_MREAD: begin
        out_nxt.program_counter_out = pc_r;
        out_nxt.read_byte = mem_q;
        out_nxt.last = 1'b1;
        out_strobe_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FETCH: begin
        hi_nxt = mem_q;
        mem_raddr = maddr(pc_r + 12'd1);
        state_nxt = S_FETCH2;
      end
      S_FETCH2: begin
        mem_raddr = maddr(pc_r + 12'd1);
        state_nxt = S_OPC;
      end
      S_OPC: begin
        op_nxt = {hi_r, mem_q};
        v_raddr = hi_r[3:0];
        vx_nxt = v_rdata;
        state_nxt = S_VY;
      end
      S_VY: begin
        v_raddr = op_r[7:4];
        vy_nxt = v_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        pc_nxt = pc2;
        emit = 1'b1;
        state_nxt = S_IDLE;
        if (op_r == OP_CLS) begin
          scr_clear = 1'b1;
          out_nxt.screen_cleared = 1'b1;
        end else if (op_r == OP_RET) begin
          sp_nxt = sp_dec;
          pc_nxt = stack_r[sp_dec];
        end else begin
          case (fn)
            4'h1: pc_nxt = op_r[11:0];
            4'h2: begin
              stk_we = 1'b1;
              sp_nxt = sp_inc;
              pc_nxt = op_r[11:0];
            end
            4'h3: skip = (vx_r == nn);
            4'h4: skip = (vx_r != nn);
            4'h5: skip = (n == 4'h0) && (vx_r == vy_r);
            4'h9: skip = (n == 4'h0) && (vx_r != vy_r);
            4'h6: begin v_we = 1'b1; v_wdata = nn; end
            4'h7: begin v_we = 1'b1; v_wdata = vx_r + nn; end
            4'h8: begin
              case (n)
                4'h0: begin v_we = 1'b1; v_wdata = vy_r; end
                4'h1: begin v_we = 1'b1; v_wdata = vx_r | vy_r; end
                4'h2: begin v_we = 1'b1; v_wdata = vx_r & vy_r; end
                4'h3: begin v_we = 1'b1; v_wdata = vx_r ^ vy_r; end
                4'h4: begin
                  sum = {1'b0, vx_r} + {1'b0, vy_r};
                  v_we = 1'b1; v_wdata = sum[7:0];
                  vf_we = 1'b1; vf_wdata = {7'd0, sum[8]};
                end
                4'h5: begin
                  v_we = 1'b1; v_wdata = vx_r - vy_r;
                  vf_we = 1'b1; vf_wdata = {7'd0, vx_r >= vy_r};
                end
                4'h6: begin
                  v_we = 1'b1; v_wdata = vx_r >> 1;
                  vf_we = 1'b1; vf_wdata = {7'd0, vx_r[0]};
                end
                4'h7: begin
                  v_we = 1'b1; v_wdata = vy_r - vx_r;
                  vf_we = 1'b1; vf_wdata = {7'd0, vy_r >= vx_r};
                end
                4'hE: begin
                  v_we = 1'b1; v_wdata = vx_r << 1;
                  vf_we = 1'b1; vf_wdata = {7'd0, vx_r[7]};
                end
                default: ;
              endcase
            end
            4'hA: i_nxt = op_r[11:0];
            4'hB: pc_nxt = op_r[11:0] + {4'd0, v_r[0]};
            4'hC: begin v_we = 1'b1; v_wdata = item_r.item.random_byte & nn; end
            4'hD: begin
              vf_we = 1'b1;
              if (n == 4'h0) begin
                scr_raddr = vy_r[4:0];
                out_nxt.display_row = scr_rdata;
                out_nxt.row_number = vy_r[4:0];
              end else begin
                emit = 1'b0;
                k_nxt = 4'd0;
                col_nxt = 1'b0;
                state_nxt = S_DRAW_RD;
              end
            end
            4'hE: begin
              if ((op_r & OP_SKP_MASK) == OP_SKP)
                skip = item_r.item.keys_down[vx_r[3:0]];
              else if ((op_r & OP_SKP_MASK) == OP_SKNP)
                skip = !item_r.item.keys_down[vx_r[3:0]];
            end
            4'hF: begin
              case (nn)
                F_LDDT: begin v_we = 1'b1; v_wdata = dt_r; end
                F_KEY: begin
                  if (item_r.item.keys_down == 16'd0) begin
                    pc_nxt = pc_r;
                    out_nxt.key_wait = 1'b1;
                  end else begin
                    v_we = 1'b1;
                    v_wdata = {4'd0, lowest_key(item_r.item.keys_down)};
                  end
                end
                F_SETDT: dt_nxt = vx_r;
                F_SETST: st_nxt = vx_r;
                F_ADDI:  i_nxt = i_r + {4'd0, vx_r};
                F_FONT:  i_nxt = FONT_BASE + 12'(vx_r[3:0]) * 12'd5;
                F_BCD: begin emit = 1'b0; k_nxt = 4'd0; state_nxt = S_BCD; end
                F_STORE: begin emit = 1'b0; k_nxt = 4'd0; state_nxt = S_STORE; end
                F_LOADR: begin emit = 1'b0; k_nxt = 4'd0; state_nxt = S_LD_RD; end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        if (skip) pc_nxt = pc_r + 12'd4;
        if (emit) begin
          out_nxt.opcode = op_r;
          out_nxt.program_counter_out = pc_nxt;
          out_nxt.last = 1'b1;
          out_strobe_nxt = 1'b1;
        end
      end
      S_DRAW_RD: begin
        mem_raddr = maddr(i_r + {8'd0, k_r});
        state_nxt = S_DRAW_WR;
      end
      S_DRAW_WR: begin
        scr_raddr = vy_r[4:0] + {1'b0, k_r};
        dbl = {mem_q, 56'd0, mem_q, 56'd0} >> vx_r[5:0];
        mask = dbl[63:0];
        nrow = scr_rdata ^ mask;
        coln = col_r || ((scr_rdata & mask) != 64'd0);
        klast = (k_r == n - 4'd1);
        scr_we = 1'b1; scr_waddr = scr_raddr; scr_wdata = nrow;
        vf_we = 1'b1; vf_wdata = {7'd0, coln};
        col_nxt = coln;
        out_nxt.opcode = op_r;
        out_nxt.program_counter_out = pc_r;
        out_nxt.display_row = nrow;
        out_nxt.row_number = scr_raddr;
        out_nxt.sprite_bits = mem_q;
        out_nxt.collision = coln;
        out_nxt.last = klast;
        out_strobe_nxt = 1'b1;
        k_nxt = k_r + 4'd1;
        state_nxt = klast ? S_IDLE : S_DRAW_RD;
      end
      S_BCD: begin
        mem_we = 1'b1;
        mem_waddr = maddr(i_r + {8'd0, k_r});
        mem_wdata = bcd_digit(vx_r, k_r[1:0]);
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd2) begin
          out_nxt.opcode = op_r; out_nxt.program_counter_out = pc_r;
          out_nxt.last = 1'b1; out_strobe_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_STORE: begin
        v_raddr = k_r;
        mem_we = 1'b1;
        mem_waddr = maddr(i_r + {8'd0, k_r});
        mem_wdata = v_rdata;
        k_nxt = k_r + 4'd1;
        if (k_r == x) begin
          out_nxt.opcode = op_r; out_nxt.program_counter_out = pc_r;
          out_nxt.last = 1'b1; out_strobe_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LD_RD: begin
        mem_raddr = maddr(i_r + {8'd0, k_r});
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        v_we = 1'b1; v_waddr = k_r; v_wdata = mem_q;
        k_nxt = k_r + 4'd1;
        state_nxt = S_LD_RD;
        if (k_r == x) begin
          out_nxt.opcode = op_r; out_nxt.program_counter_out = pc_r;
          out_nxt.last = 1'b1; out_strobe_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; hi_r <= hi_nxt; vx_r <= vx_nxt; vy_r <= vy_nxt;
    item_r <= item_nxt; k_r <= k_nxt; col_r <= col_nxt; out_r <= out_nxt;
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_cnt_r <= '0;
      pc_r <= START_PC; i_r <= 12'd0; sp_r <= '0; dt_r <= 8'd0; st_r <= 8'd0;
      out_strobe_r <= 1'b0;
      for (int j = 0; j < 16; j++) v_r[j] <= 8'd0;
      for (int j = 0; j < STACK_DEPTH; j++) stack_r[j] <= 12'd0;
      for (int j = 0; j < SCREEN_ROWS; j++) screen_r[j] <= 64'd0;
    end else begin
      state_r <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      pc_r <= pc_nxt; i_r <= i_nxt; sp_r <= sp_nxt; dt_r <= dt_nxt; st_r <= st_nxt;
      out_strobe_r <= out_strobe_nxt;
      // The flag write to VF takes priority over a result aimed at VF.
      if (v_we && !(vf_we && v_waddr == 4'hF)) v_r[v_waddr] <= v_wdata;
      if (vf_we) v_r[15] <= vf_wdata;
      if (stk_we) stack_r[sp_r] <= pc_r + 12'd2;
      if (scr_clear) begin
        for (int j = 0; j < SCREEN_ROWS; j++) screen_r[j] <= 64'd0;
      end else if (scr_we) begin
        screen_r[scr_waddr] <= scr_wdata;
      end
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !pop) else $error("command taken during memory clear");
  a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.last) |-> (state_r == S_IDLE))
    else $error("final result but sequencer still working");
  a_mid_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_r.last) |-> (state_r == S_DRAW_RD))
    else $error("non-final result outside a sprite draw");

endmodule

### design/chip8_instruction_core.sv
// Top level of the CHIP-8 instruction core: command front end plus execution back end.
// Depends on c8_pkg, c8_front and c8_back.
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low; its results come out
// on out_item, each marked by out_strobe for exactly one cycle, and the
// receiver cannot stall them, so each strobed transfer must be taken.
// After reset the core clears all MEMORY_BYTES bytes of memory and places the
// font at 0x050, with busy high. A memory load or screen row read is done as it
// leaves the queue and its result is registered; a memory read adds S_MREAD for
// the memory output. An executed instruction leaves the queue and starts the
// fetch, passes S_FETCH and S_FETCH2, reads VX and VY (S_OPC, S_VY), executes
// (S_EXEC) and registers the result. A sprite draw of N rows then does a memory
// read (S_DRAW_RD) and a screen update (S_DRAW_WR) per row, one result per row;
// BCD writes three digits, register store X+1 registers, register load X+1 in
// turn. The back end sequencer carries out one command at a time; a two-entry
// queue lets up to two commands be taken ahead of the one being carried out.
module chip8_instruction_core #(
  parameter int MEMORY_BYTES = 4096,
  parameter int STACK_DEPTH  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  c8_pkg::in_item_t  in_item,
  output logic              out_strobe,
  output c8_pkg::out_item_t out_item
);
  import c8_pkg::*;

  logic q_valid, pop, clearing;
  cmd_t q_cmd;

  // Front end: accepts and classifies commands into the queue.
  c8_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
    .hold(clearing), .pop(pop), .busy(busy), .q_valid(q_valid), .q_cmd(q_cmd)
  );

  // Back end: holds all machine state and carries out one command at a time.
  c8_back #(.MEMORY_BYTES(MEMORY_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .pop(pop),
    .clearing(clearing), .out_strobe(out_strobe), .out_item(out_item)
  );

endmodule

### test/chip8_instruction_core_test.sv
// Self-checking testbench for chip8_instruction_core: memory loads and reads, screen row
// reads and instruction execution, checked against a behavioral CHIP-8 predictor.
// Depends on c8_pkg and the chip8_instruction_core RTL.
`timescale 1ns / 1ps
module chip8_instruction_core_test;
  import c8_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  chip8_instruction_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  // Commands waiting to be put on the input port, and results the predictor
  // says the core still owes us, oldest first.
  in_item_t  pending_cmds[$];
  out_item_t expected_results[$];

  // The predictor's own copy of the machine state.
  logic [7:0]  mem_image [4096];
  logic [63:0] screen_image [32];
  logic [7:0]  vreg [16];
  logic [11:0] index_reg;
  logic [11:0] pc_reg;
  logic [11:0] call_stack [16];
  logic [3:0]  stack_ptr;
  logic [7:0]  delay_reg;
  logic [7:0]  sound_reg;

  int  mismatches;
  int  results_seen;
  int  cmds_taken;
  int  draws_seen;
  int  idle_left;
  bit  no_idle;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t blank_result();
    out_item_t r;
    r = '0;
    r.last = 1'b1;
    return r;
  endfunction

  // Works out every result that one accepted command causes and updates the
  // predicted machine state, in the same order the instruction set defines.
  task automatic chip8_execute(input in_item_t cmd);
    out_item_t   r;
    logic [15:0] op;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [8:0]  wide;
    logic [7:0]  res;
    logic        flag;
    logic        sets_flag;
    logic        known;
    logic [5:0]  x0;
    logic [4:0]  y0;
    logic [4:0]  row;
    logic [7:0]  spr;
    logic [63:0] mask;
    logic        col;
    bit          clr;
    bit          kw;
    bit          found;
    r = blank_result();
    case (cmd.func)
      FUNC_LOAD: begin
        mem_image[cmd.address] = cmd.load_byte;
        r.program_counter_out = pc_reg;
        expected_results.push_back(r);
        return;
      end
      FUNC_MREAD: begin
        r.read_byte = mem_image[cmd.address];
        r.program_counter_out = pc_reg;
        expected_results.push_back(r);
        return;
      end
      FUNC_DREAD: begin
        r.row_number = cmd.address[4:0];
        r.display_row = screen_image[cmd.address[4:0]];
        r.program_counter_out = pc_reg;
        expected_results.push_back(r);
        return;
      end
      default: ;
    endcase

    op  = {mem_image[pc_reg], mem_image[12'(pc_reg + 12'd1)]};
    x   = op[11:8];
    y   = op[7:4];
    n   = op[3:0];
    nn  = op[7:0];
    nnn = op[11:0];
    vx  = vreg[x];
    vy  = vreg[y];
    clr = 0;
    kw  = 0;
    pc_reg = pc_reg + 12'd2;

    if (op == OP_CLS) begin
      foreach (screen_image[i]) screen_image[i] = '0;
      clr = 1;
    end else if (op == OP_RET) begin
      stack_ptr = stack_ptr - 4'd1;
      pc_reg = call_stack[stack_ptr];
    end else if (op[15:12] == 4'h1) begin
      pc_reg = nnn;
    end else if (op[15:12] == 4'h2) begin
      call_stack[stack_ptr] = pc_reg;
      stack_ptr = stack_ptr + 4'd1;
      pc_reg = nnn;
    end else if (op[15:12] == 4'h3 || op[15:12] == 4'h4 ||
                 ((op[15:12] == 4'h5 || op[15:12] == 4'h9) && n == 4'h0)) begin
      case (op[15:12])
        4'h3:    flag = (vx == nn);
        4'h4:    flag = (vx != nn);
        4'h5:    flag = (vx == vy);
        default: flag = (vx != vy);
      endcase
      if (flag) pc_reg = pc_reg + 12'd2;
    end else if (op[15:12] == 4'h6) begin
      vreg[x] = nn;
    end else if (op[15:12] == 4'h7) begin
      vreg[x] = vx + nn;
    end else if (op[15:12] == 4'h8) begin
      sets_flag = 1;
      known = 1;
      flag = 0;
      res = vx;
      case (n)
        4'h0: begin res = vy; sets_flag = 0; end
        4'h1: begin res = vx | vy; sets_flag = 0; end
        4'h2: begin res = vx & vy; sets_flag = 0; end
        4'h3: begin res = vx ^ vy; sets_flag = 0; end
        4'h4: begin wide = {1'b0, vx} + {1'b0, vy}; res = wide[7:0]; flag = wide[8]; end
        4'h5: begin res = vx - vy; flag = (vx >= vy); end
        4'h6: begin res = vx >> 1; flag = vx[0]; end
        4'h7: begin res = vy - vx; flag = (vy >= vx); end
        4'hE: begin res = vx << 1; flag = vx[7]; end
        default: known = 0;
      endcase
      if (known) begin
        vreg[x] = res;
        // The flag goes in last, so it overrides the result when X is F.
        if (sets_flag) vreg[15] = {7'd0, flag};
      end
    end else if (op[15:12] == 4'hA) begin
      index_reg = nnn;
    end else if (op[15:12] == 4'hB) begin
      pc_reg = nnn + {4'd0, vreg[0]};
    end else if (op[15:12] == 4'hC) begin
      vreg[x] = cmd.random_byte & nn;
    end else if (op[15:12] == 4'hD) begin
      x0 = vx[5:0];
      y0 = vy[4:0];
      col = 0;
      vreg[15] = 8'd0;
      r.opcode = op;
      r.program_counter_out = pc_reg;
      draws_seen++;
      if (n == 4'h0) begin
        r.row_number = y0;
        r.display_row = screen_image[y0];
        expected_results.push_back(r);
        return;
      end
      for (int k = 0; k < n; k++) begin
        spr = mem_image[12'(index_reg + 12'(k))];
        row = 5'(y0 + 5'(k));
        mask = '0;
        for (int w = 0; w < 8; w++) begin
          if (spr[7 - w]) mask[63 - 6'(x0 + 6'(w))] = 1'b1;
        end
        if ((screen_image[row] & mask) != '0) col = 1;
        screen_image[row] ^= mask;
        vreg[15] = {7'd0, col};
        r.display_row = screen_image[row];
        r.row_number = row;
        r.sprite_bits = spr;
        r.collision = col;
        r.last = (k == n - 1);
        expected_results.push_back(r);
      end
      return;
    end else if ((op & OP_SKP_MASK) == OP_SKP) begin
      if (cmd.keys_down[vx[3:0]]) pc_reg = pc_reg + 12'd2;
    end else if ((op & OP_SKP_MASK) == OP_SKNP) begin
      if (!cmd.keys_down[vx[3:0]]) pc_reg = pc_reg + 12'd2;
    end else if (op[15:12] == 4'hF) begin
      case (nn)
        F_LDDT:  vreg[x] = delay_reg;
        F_KEY: begin
          if (cmd.keys_down == '0) begin
            pc_reg = pc_reg - 12'd2;
            kw = 1;
          end else begin
            found = 0;
            for (int j = 0; j < 16; j++) begin
              if (!found && cmd.keys_down[j]) begin
                vreg[x] = 8'(j);
                found = 1;
              end
            end
          end
        end
        F_SETDT: delay_reg = vx;
        F_SETST: sound_reg = vx;
        F_ADDI:  index_reg = index_reg + {4'd0, vx};
        F_FONT:  index_reg = FONT_BASE + 12'(vx[3:0]) * 12'd5;
        F_BCD: begin
          mem_image[index_reg] = vx / 8'd100;
          mem_image[12'(index_reg + 12'd1)] = (vx / 8'd10) % 8'd10;
          mem_image[12'(index_reg + 12'd2)] = vx % 8'd10;
        end
        F_STORE: for (int j = 0; j <= x; j++) mem_image[12'(index_reg + 12'(j))] = vreg[j];
        F_LOADR: for (int j = 0; j <= x; j++) vreg[j] = mem_image[12'(index_reg + 12'(j))];
        default: ;
      endcase
    end
    // Anything not matched above is an unknown opcode: only the pc moves.
    r.opcode = op;
    r.program_counter_out = pc_reg;
    r.screen_cleared = clr;
    r.key_wait = kw;
    expected_results.push_back(r);
  endtask

  // Driver. A transfer happens at an edge where start is high and busy is low;
  // the accepted command is predicted right there, then the next one (or an
  // idle gap) is put on the port with the same nonblocking update.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        chip8_execute(in_item);
        cmds_taken++;
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
          idle_left = $urandom_range(1, 5) - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_item <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor. Results cannot be held off, so every strobed cycle is one
  // transfer that is checked field by field against the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    string     bad;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", out_item);
      end else begin
        e = expected_results.pop_front();
        bad = "";
        if (out_item.opcode != e.opcode) bad = {bad, " opcode"};
        if (out_item.program_counter_out != e.program_counter_out) bad = {bad, " pc"};
        if (out_item.read_byte != e.read_byte) bad = {bad, " read_byte"};
        if (out_item.display_row != e.display_row) bad = {bad, " display_row"};
        if (out_item.row_number != e.row_number) bad = {bad, " row_number"};
        if (out_item.sprite_bits != e.sprite_bits) bad = {bad, " sprite_bits"};
        if (out_item.collision != e.collision) bad = {bad, " collision"};
        if (out_item.screen_cleared != e.screen_cleared) bad = {bad, " screen_cleared"};
        if (out_item.key_wait != e.key_wait) bad = {bad, " key_wait"};
        if (out_item.last != e.last) bad = {bad, " last"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d differs in%s\n  expected %h\n  actual   %h",
                     results_seen, bad, e, out_item);
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either side. The limit covers
  // the memory clearing pass after reset with plenty to spare.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Waits until every queued command has been taken, so the predictor's pc is
  // the one the next executed instruction will be fetched from.
  task automatic wait_all_taken();
    @(negedge clk);
    while (pending_cmds.size() != 0 || start) @(negedge clk);
  endtask

  function automatic in_item_t make_cmd(logic [1:0] f, logic [11:0] a, logic [7:0] b);
    in_item_t c;
    c.func = f;
    c.address = a;
    c.load_byte = b;
    c.keys_down = 16'($urandom);
    c.random_byte = 8'($urandom);
    return c;
  endfunction

  // Places one instruction at the current pc and then executes it.
  task automatic run_instruction(input logic [15:0] op, input logic [15:0] keys);
    in_item_t c;
    wait_all_taken();
    pending_cmds.push_back(make_cmd(FUNC_LOAD, pc_reg, op[15:8]));
    pending_cmds.push_back(make_cmd(FUNC_LOAD, 12'(pc_reg + 12'd1), op[7:0]));
    c = make_cmd(FUNC_EXEC, 12'($urandom), 8'($urandom));
    c.keys_down = keys;
    pending_cmds.push_back(c);
  endtask

  // A random but well-formed instruction, weighted so that skips are taken
  // about half the time and draws use readable sprite data.
  function automatic logic [15:0] random_instruction();
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  nn;
    logic [3:0]  alu [10];
    x  = 4'($urandom);
    y  = 4'($urandom);
    nn = ($urandom_range(0, 1) == 0) ? vreg[x] : 8'($urandom);
    alu = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE, 4'($urandom)};
    case ($urandom_range(0, 20))
      0:  return OP_CLS;
      1:  return OP_RET;
      2:  return {4'h1, 12'($urandom)};
      3:  return {4'h2, 12'($urandom)};
      4:  return {4'h3, x, nn};
      5:  return {4'h4, x, nn};
      6:  return {4'h5, x, ($urandom_range(0, 1) ? x : y), 4'h0};
      7:  return {4'h9, x, y, 4'h0};
      8, 9: return {4'h6, x, 8'($urandom)};
      10: return {4'h7, x, 8'($urandom)};
      11, 12: return {4'h8, x, y, alu[$urandom_range(0, 9)]};
      13: return {4'hA, 12'($urandom)};
      14: return {4'hB, 12'($urandom)};
      15: return {4'hC, x, 8'($urandom)};
      16, 17: return {4'hD, x, y, 4'($urandom)};
      18: return {4'hE, x, ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
      19: begin
        case ($urandom_range(0, 9))
          0: return {4'hF, x, F_LDDT};
          1: return {4'hF, x, F_KEY};
          2: return {4'hF, x, F_SETDT};
          3: return {4'hF, x, F_SETST};
          4: return {4'hF, x, F_ADDI};
          5: return {4'hF, x, F_FONT};
          6: return {4'hF, x, F_BCD};
          7: return {4'hF, x, F_STORE};
          8: return {4'hF, x, F_LOADR};
          default: return {4'hF, x, 8'($urandom)};
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_keys();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'h1 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    in_item_t c;
    int       sent;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    mismatches = 0;
    results_seen = 0;
    cmds_taken = 0;
    draws_seen = 0;
    idle_left = 0;
    no_idle = 0;
    quiet_cycles = 0;
    foreach (mem_image[i]) mem_image[i] = '0;
    for (int i = 0; i < FONT_LEN; i++) mem_image[FONT_BASE + 12'(i)] = FONT[i];
    foreach (screen_image[i]) screen_image[i] = '0;
    foreach (vreg[i]) vreg[i] = '0;
    foreach (call_stack[i]) call_stack[i] = '0;
    index_reg = '0;
    pc_reg = START_PC;
    stack_ptr = '0;
    delay_reg = '0;
    sound_reg = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: memory edges, the font, a return on an empty stack, flag
    // arithmetic with X = F, key wait with and without keys, a font draw that
    // wraps at the right and bottom edges and collides, and an empty draw.
    pending_cmds.push_back(make_cmd(FUNC_MREAD, FONT_BASE, 8'h00));
    pending_cmds.push_back(make_cmd(FUNC_LOAD, 12'hFFF, 8'hFF));
    pending_cmds.push_back(make_cmd(FUNC_MREAD, 12'hFFF, 8'h00));
    pending_cmds.push_back(make_cmd(FUNC_DREAD, 12'h01F, 8'h00));
    run_instruction(OP_RET, 16'h0000);
    run_instruction(16'h6FFF, 16'hFFFF);
    run_instruction(16'h8FF4, 16'h0000);
    run_instruction({4'hF, 4'h3, F_KEY}, 16'h0000);
    run_instruction({4'hF, 4'h3, F_KEY}, 16'h8010);
    run_instruction(16'h603E, 16'h0000);
    run_instruction(16'h611E, 16'h0000);
    run_instruction({4'hF, 4'h0, F_FONT}, 16'h0000);
    run_instruction(16'hD015, 16'h0000);
    run_instruction(16'hD015, 16'h0000);
    run_instruction(16'hD010, 16'h0000);

    // Random part: mostly well-formed instructions with random content, the
    // rest loose loads, reads and executes of whatever sits at the pc.
    sent = 0;
    while (sent < 133) begin
      if (sent > 105) no_idle = 1;
      if ($urandom_range(0, 4) != 0) begin
        run_instruction(random_instruction(), random_keys());
        sent += 3;
      end else begin
        c = make_cmd(2'($urandom), 12'($urandom), 8'($urandom));
        // Loose loads sometimes aim near I so draws pick up nonzero sprites.
        if (c.func == FUNC_LOAD && $urandom_range(0, 1))
          c.address = index_reg + 12'($urandom_range(0, 15));
        pending_cmds.push_back(c);
        sent++;
      end
    end

    wait_all_taken();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d commands (%0d draws) and checked %0d results, %0d mismatches.",
             cmds_taken, draws_seen, results_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
